@@ rtl/trdp_pkg.sv @@
// Shared types, character codes and status codes for the tab record decimal parser.
// No dependencies; used by trdp_core and tab_record_decimal_parser.
package trdp_pkg;

  // Parse phase codes
  localparam logic [1:0] PH_SEEK   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NUL   = 2'd1;
  localparam logic [1:0] ST_EOL   = 2'd2;
  localparam logic [1:0] ST_DIGIT = 2'd3;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned VALUE_W = 64;

  typedef logic [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic [1:0] phase;
    value_t     acc;
    logic       neg;
  } trdp_state_t;

  typedef struct packed {
    logic       valid;
    value_t     value;
    logic [1:0] status;
  } trdp_result_t;

endpackage

@@ rtl/tab_record_decimal_parser.sv @@
// Top level of the tab record decimal parser: input byte register, parse state,
// result register. Depends on trdp_pkg and trdp_core.
//
// Usage:
//   The slave channel (in_*) carries one text byte per transfer in in_tdata.
//   Records look like: label, TAB, optional '-', decimal digits, optional CRs, LF.
//   The label is skipped; digits accumulate modulo 2^64.
//   The master channel (out_*) carries one result per finished record:
//   out_tdata holds the signed 64-bit value, out_tuser the status
//   (ok, NUL end of string, LF before TAB, invalid digit). Errors give value 0.
//   Bytes that finish no record produce no transfer on the master side.
// Timing:
//   A byte accepted into the input register is parsed there; a result it causes
//   is registered when the byte advances and is on out_* from then on. One byte
//   per cycle is sustained unless a result-making byte is blocked: the single
//   parse step (a 64-bit shift-add) between the input and result registers sets it.
// Stalls and reset:
//   While a result waits on out_tready, bytes that produce no result still
//   advance; a byte that would produce a result holds the input register and
//   in_tready drops. rst_n (synchronous, active low) empties both registers and
//   returns the parser to seeking the tab with a zero accumulator.
module tab_record_decimal_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value (signed)
  output logic [1:0]  out_tuser   // [1:0] status
);
  import trdp_pkg::*;

  logic         stage_valid_r;
  logic [7:0]   stage_char_r;
  trdp_state_t  state_r;
  trdp_state_t  state_nxt;
  trdp_result_t res;
  logic         out_valid_r;
  value_t       out_value_r;
  logic [1:0]   out_status_r;
  logic         advance;

  trdp_core u_core (
    .state_i  (state_r),
    .char_i   (stage_char_r),
    .state_o  (state_nxt),
    .result_o (res)
  );

  // the staged byte moves on unless it makes a result and the result slot is taken
  assign advance   = stage_valid_r && (!res.valid || !out_valid_r || out_tready);
  assign in_tready = !stage_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_tready) begin
      stage_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stage_char_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_SEEK, acc: '0, neg: 1'b0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_value_r  <= res.value;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

`ifndef ASSERT_OFF
  // error results always carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata == '0))
    else $error("error result with nonzero value");

  // a result resets the parse state
  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.valid |=> (state_r.phase == PH_SEEK) && (state_r.acc == '0) && !state_r.neg)
    else $error("parse state not cleared after result");

  // input held off only while a byte is staged and blocked
  a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> stage_valid_r && res.valid && out_valid_r && !out_tready)
    else $error("in_tready low without a blocked result");

  // a blocked staged byte is kept for the next cycle
  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && !advance |=> stage_valid_r && $stable(stage_char_r) && $stable(state_r))
    else $error("staged byte or state lost while blocked");

  // a pending result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(advance && res.valid))
    else $error("pending result overwritten");
`endif

endmodule

@@ rtl/trdp_core.sv @@
// Next-state and result logic for one text byte of the tab record parser.
// Depends on trdp_pkg.
module trdp_core (
  input  trdp_pkg::trdp_state_t  state_i,
  input  logic [7:0]             char_i,
  output trdp_pkg::trdp_state_t  state_o,
  output trdp_pkg::trdp_result_t result_o
);
  import trdp_pkg::*;

  value_t acc_x10;
  value_t acc_next;
  value_t signed_acc;
  logic   is_digit;

  // acc * 10 as a shift-add; digit is the low nibble of '0'..'9'
  assign acc_x10    = {state_i.acc[VALUE_W-4:0], 3'b000} + {state_i.acc[VALUE_W-2:0], 1'b0};
  assign acc_next   = acc_x10 + {{(VALUE_W-4){1'b0}}, char_i[3:0]};
  assign signed_acc = state_i.neg ? (~state_i.acc + value_t'(1)) : state_i.acc;
  assign is_digit   = (char_i >= CH_ZERO) && (char_i <= CH_NINE);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if ((state_i.phase == PH_FIRST) || (state_i.phase == PH_DIGITS)) begin
      state_o.phase = PH_DIGITS;
      priority if ((state_i.phase == PH_FIRST) && (char_i == CH_MINUS)) begin
        state_o.neg = 1'b1;
      end else if (char_i == CH_NUL) begin
        result_o = '{valid: 1'b1, value: '0, status: ST_NUL};
      end else if (char_i == CH_CR) begin
        // carriage return: skipped, sign window closes
      end else if (char_i == CH_LF) begin
        result_o = '{valid: 1'b1, value: signed_acc, status: ST_OK};
      end else if (!is_digit) begin
        result_o = '{valid: 1'b1, value: '0, status: ST_DIGIT};
      end else begin
        state_o.acc = acc_next;
      end
    end else begin
      // seeking the tab; the unused phase code behaves the same
      priority if (char_i == CH_NUL) begin
        result_o = '{valid: 1'b1, value: '0, status: ST_NUL};
      end else if (char_i == CH_LF) begin
        result_o = '{valid: 1'b1, value: '0, status: ST_EOL};
      end else if (char_i == CH_TAB) begin
        state_o = '{phase: PH_FIRST, acc: '0, neg: 1'b0};
      end else begin
        state_o.phase = PH_SEEK;
      end
    end
    // every result sends the parser back to the label
    if (result_o.valid) begin
      state_o = '{phase: PH_SEEK, acc: '0, neg: 1'b0};
    end
  end

endmodule

@@ tb/tab_record_decimal_parser_tb.sv @@
// Testbench for tab_record_decimal_parser: a behavioral predictor checks every result
// transfer. Depends on trdp_pkg and the tab_record_decimal_parser RTL.
module tab_record_decimal_parser_tb;
  import trdp_pkg::*;

  // One expected result: signed value (raw bits) and status code
  typedef struct packed {
    value_t     value;
    logic [1:0] status;
  } parse_result_t;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_ITEMS = 340;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  tab_record_decimal_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] char_in
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [63:0] value (signed)
    .out_tuser  (out_tuser)    // [1:0] status
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: mirrors the parser's phase, accumulator and sign flag
  logic [1:0]    prs_phase = PH_SEEK;
  value_t        prs_acc = '0;
  logic          prs_neg = 1'b0;
  parse_result_t pending_results[$];

  int unsigned sent_cnt = 0;  // input transfers so far
  int unsigned fault_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Sender pacing: bursts of random length, random gaps in between
  bit          pace_on = 1'b1;
  int unsigned max_gap = 4;
  int unsigned burst_left = 0;

  // Receiver pacing: random stall runs, plus a long hold-off on request
  int unsigned stall_pct = 30;
  int unsigned stall_len = 4;
  int unsigned stall_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  function automatic void clear_parse();
    prs_phase = PH_SEEK;
    prs_acc = '0;
    prs_neg = 1'b0;
  endfunction

  // Advances the predictor by one byte; returns 1 when the byte finishes a record
  function automatic bit parse_char(input logic [7:0] c, output parse_result_t r);
    r.value = '0;
    r.status = ST_OK;
    // Anything but the two number phases counts as seeking the tab
    if (prs_phase != PH_FIRST && prs_phase != PH_DIGITS) begin
      if (c == CH_NUL) begin
        r.status = ST_NUL;
        clear_parse();
        return 1'b1;
      end
      if (c == CH_LF) begin
        r.status = ST_EOL;
        clear_parse();
        return 1'b1;
      end
      if (c == CH_TAB) begin
        prs_phase = PH_FIRST;
        prs_acc = '0;
        prs_neg = 1'b0;
      end
      return 1'b0;
    end
    // Only the very first byte after the tab may be the sign
    if (prs_phase == PH_FIRST) begin
      prs_phase = PH_DIGITS;
      if (c == CH_MINUS) begin
        prs_neg = 1'b1;
        return 1'b0;
      end
    end
    if (c == CH_NUL) begin
      r.status = ST_NUL;
      clear_parse();
      return 1'b1;
    end
    if (c == CH_CR)
      return 1'b0;
    if (c == CH_LF) begin
      r.value = prs_neg ? ('0 - prs_acc) : prs_acc;
      clear_parse();
      return 1'b1;
    end
    if (c < CH_ZERO || c > CH_NINE) begin
      r.status = ST_DIGIT;
      clear_parse();
      return 1'b1;
    end
    // Wraps modulo 2^64, no overflow flag
    prs_acc = prs_acc * 64'd10 + {56'd0, c - CH_ZERO};
    return 1'b0;
  endfunction

  // Offers one byte, waits for its transfer, then records what it should cause
  task automatic send_char(input logic [7:0] c);
    parse_result_t r;
    int unsigned   gap;
    if (pace_on && burst_left == 0) begin
      gap = $urandom_range(1, max_gap);
      burst_left = $urandom_range(1, 24);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0)
      burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= c;
    // Values seen here are the ones from just before the edge
    do @(posedge clk); while (!in_tready);
    if (parse_char(c, r))
      pending_results.push_back(r);
    sent_cnt++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i]);
  endtask

  // Stops offering and waits until every expected result has been seen
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Builds one record with random content: mostly well formed, some broken, some noise
  task automatic send_record();
    logic [7:0]  rec[$];
    int unsigned kind;
    int unsigned n_label;
    int unsigned n_dig;
    int unsigned pos;
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      // Noise over the full byte range
      repeat ($urandom_range(1, 4))
        send_char(8'($urandom_range(0, 255)));
      return;
    end
    n_label = $urandom_range(0, 3);
    repeat (n_label)
      rec.push_back(8'($urandom_range(8'h20, 8'hFF)));
    rec.push_back(CH_TAB);
    if ($urandom_range(0, 3) == 0)
      rec.push_back(CH_MINUS);
    // Occasionally long enough to wrap the accumulator
    n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(0, 6);
    repeat (n_dig) begin
      rec.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 7) == 0)
        rec.push_back(CH_CR);
    end
    rec.push_back(CH_LF);
    if (kind >= 80) begin
      pos = $urandom_range(0, rec.size() - 1);
      case ($urandom_range(0, 3))
        0: rec[pos] = CH_NUL;
        1: rec[pos] = CH_LF;
        2: rec[pos] = CH_MINUS;
        default: rec[pos] = 8'($urandom_range(0, 255));
      endcase
    end
    foreach (rec[i])
      send_char(rec[i]);
  endtask

  // Short cases: empty numbers, sign rules, CR handling, every error status
  task automatic test_special_cases();
    pace_on = 1'b1;
    max_gap = 3;
    stall_pct = 30;
    send_text("\t\n");          // empty number
    send_text("\t-\n");         // sign alone
    send_text("\t\r-1\n");      // CR first blocks the sign; then LF before tab
    send_text("\t7-");          // minus after a digit
    send_char(8'hFF);           // high byte in the label is skipped
    send_text("\t1\r2\r\n");
    send_char(CH_NUL);          // NUL while seeking
    send_text("\t4");
    send_char(CH_NUL);          // NUL inside the number
    send_text("\t");
    send_char(8'h80);           // high byte in the number
    send_text("\t/\t:");        // just outside the digit range
    drain();
  endtask

  // Value extremes and wrap-around
  task automatic test_value_extremes();
    pace_on = 1'b0;
    stall_pct = 0;
    send_text("\t9223372036854775807\n");
    send_text("\t-9223372036854775808\n");
    send_text("\t18446744073709551615\n");
    send_text("\t18446744073709551616\n");
    send_text("\t-99999999999999999999999\n");
    drain();
  endtask

  // Random records with changing pacing on both sides
  task automatic test_random_records();
    int unsigned start_cnt;
    int unsigned rec_cnt;
    start_cnt = sent_cnt;
    rec_cnt = 0;
    while (sent_cnt - start_cnt < RANDOM_ITEMS) begin
      if (rec_cnt % 10 == 0) begin
        pace_on = ($urandom_range(0, 3) != 0);
        max_gap = $urandom_range(1, 6);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 25;
          default: stall_pct = 60;
        endcase
        stall_len = $urandom_range(1, 6);
      end
      send_record();
      rec_cnt++;
    end
    drain();
  endtask

  // Receiver holds off for a long stretch while bytes keep coming: input must stall
  task automatic test_output_backpressure();
    pace_on = 1'b0;
    stall_pct = 0;
    hold_req = 300;
    repeat (20) begin
      send_text("\t");
      send_char(CH_ZERO + 8'($urandom_range(0, 9)));
      send_char(CH_LF);
    end
    drain();
  endtask

  // Receiver pacing, its own process
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, stall_len - 1);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker: each transfer against the oldest expectation
  always @(posedge clk) begin : check_result
    parse_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("unexpected result: value=%0d status=%0d", $signed(out_tdata), out_tuser);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata !== exp_r.value || out_tuser !== exp_r.status) begin
          fault_cnt++;
          if (fault_cnt <= 10)
            $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                     $signed(exp_r.value), exp_r.status, $signed(out_tdata), out_tuser);
        end
      end
    end
  end

  // Global watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_value_extremes();
    test_random_records();
    test_output_backpressure();
    drain();
    repeat (8) @(posedge clk);
    if (fault_cnt == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
